[rtl/ctrvpmu_pkg.sv]
`timescale 1ns / 1ps

package ctrvpmu_pkg;

	localparam int ANGLE_ITERATIONS = 24;
	localparam int CW = 34;
	localparam int NW = 56;
	localparam int DW = 34;
	localparam logic [17:0] TURN_SCALE = 18'd166886;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [7:0] REG_STEP_TIME = 8'd0;
	localparam logic [7:0] REG_NEAR_ZERO_RATE = 8'd1;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0] heading;
		logic signed [23:0] speed;
		logic signed [27:0] turn_rate;
		logic last_in_batch;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic [31:0] new_heading;
		logic saturated;
		logic last_out;
	} out_item_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [DW:0] rem;
		logic [NW-1:0] nq;
		logic [DW-1:0] dv;
	} div_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

[rtl/ctrvpmu_cordic_cell.sv]
`timescale 1ns / 1ps

module ctrvpmu_cordic_cell import ctrvpmu_pkg::*; (
	input logic clk,
	input logic en,
	input logic [4:0] idx,
	input cordic_t d,
	output cordic_t q
);

	logic signed [CW-1:0] sx;
	logic signed [CW-1:0] sy;
	logic signed [CW-1:0] at;

	always_comb begin
		sx = $signed(d.y) >>> idx;
		sy = $signed(d.x) >>> idx;
		at = $signed({2'b00, atan_lut(idx)});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!d.z[CW-1]) begin
				q.x <= $signed(d.x) - sx;
				q.y <= $signed(d.y) + sy;
				q.z <= $signed(d.z) - at;
			end else begin
				q.x <= $signed(d.x) + sx;
				q.y <= $signed(d.y) - sy;
				q.z <= $signed(d.z) + at;
			end
		end
	end

endmodule

[rtl/ctrvpmu_div_cell.sv]
`timescale 1ns / 1ps

module ctrvpmu_div_cell import ctrvpmu_pkg::*; (
	input logic clk,
	input logic en,
	input div_t d,
	output div_t q
);

	logic [DW:0] r2;
	logic ge;

	always_comb begin
		r2 = {d.rem[DW-1:0], d.nq[NW-1]};
		ge = r2 >= {1'b0, d.dv};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.rem <= ge ? r2 - {1'b0, d.dv} : r2;
			q.nq <= {d.nq[NW-2:0], ge};
			q.dv <= d.dv;
		end
	end

endmodule

[rtl/ctrv_particle_motion_update.sv]
`timescale 1ns / 1ps

// Motion update for one particle per item under the constant turn rate and
// velocity model. Items enter on the in channel and leave on the out channel,
// both valid/ready. The cfg channel writes step_time (index 0) and
// near_zero_rate (index 1); other indexes are ignored, and cfg_ready is
// always high. Write configuration only while the pipeline is empty.
// The block is a fixed pipeline: three input stages, two chains of
// ANGLE_ITERATIONS CORDIC cells for the old and new heading, two stages of
// products and rounding, two chains of 56 restoring divider cells, and the
// output register. One item is accepted per cycle as long as the receiver
// takes results. When the output register holds an item that is not taken,
// the whole pipeline holds and in_ready drops; nothing is lost or duplicated.
// Reset clears all valid bits and loads the register reset values.
module ctrv_particle_motion_update_core import ctrvpmu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_index,
	input logic [23:0] cfg_data
);

	localparam int N = ANGLE_ITERATIONS;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [31:0] nh;
		logic signed [23:0] v;
		logic signed [33:0] d;
		logic arc;
		logic wneg;
		logic [27:0] wmag;
		logic last;
		logic flip0;
		logic flip1;
	} side_t;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [31:0] nh;
		logic last;
		logic arc;
		logic sx;
		logic sy;
		logic signed [31:0] stdx;
		logic signed [31:0] stdy;
	} side2_t;

	logic [15:0] step_time_q;
	logic [23:0] nzr_q;
	logic en;

	assign cfg_ready = 1'b1;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= 16'd6554;
			nzr_q <= 24'd1678;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STEP_TIME: step_time_q <= cfg_data[15:0];
				REG_NEAR_ZERO_RATE: nzr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: turn angle product and speed times step time.
	logic signed [44:0] rot_c;
	logic signed [40:0] vdt_c;
	logic [27:0] wmag_c;
	in_item_t ctx_s1;
	logic signed [44:0] rot_s1;
	logic signed [40:0] vdt_s1;
	logic [27:0] wmag_s1;
	logic arc_s1;

	always_comb begin
		rot_c = in_data.turn_rate * $signed({1'b0, step_time_q});
		vdt_c = in_data.speed * $signed({1'b0, step_time_q});
		wmag_c = in_data.turn_rate[27] ? 28'(-in_data.turn_rate) : 28'(in_data.turn_rate);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= in_data;
			rot_s1 <= rot_c;
			vdt_s1 <= vdt_c;
			wmag_s1 <= wmag_c;
			arc_s1 <= wmag_c > {4'b0000, nzr_q};
		end
	end

	// Stage 2: scale to binary angle, round the straight-line distance.
	logic [43:0] rmag_c;
	logic [40:0] vmag_c;
	logic [32:0] dr_c;
	in_item_t ctx_s2;
	logic rneg_s2;
	logic [49:0] plo_s2;
	logic [29:0] phi_s2;
	logic signed [33:0] d_s2;
	logic [27:0] wmag_s2;
	logic arc_s2;

	always_comb begin
		rmag_c = rot_s1[44] ? 44'(-rot_s1) : 44'(rot_s1);
		vmag_c = vdt_s1[40] ? 41'(-vdt_s1) : 41'(vdt_s1);
		dr_c = 33'((vmag_c + 41'd128) >> 8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_s1;
			rneg_s2 <= rot_s1[44];
			plo_s2 <= rmag_c[31:0] * TURN_SCALE;
			phi_s2 <= rmag_c[43:32] * TURN_SCALE;
			d_s2 <= vdt_s1[40] ? -$signed({1'b0, dr_c}) : $signed({1'b0, dr_c});
			wmag_s2 <= wmag_s1;
			arc_s2 <= arc_s1;
		end
	end

	// Stage 3: new heading and CORDIC seeds.
	logic [61:0] hsum_c;
	logic [31:0] dth_c;
	logic [31:0] nh_c;
	logic [31:0] t0_c;
	logic [31:0] t1_c;
	logic [31:0] a0_c;
	logic [31:0] a1_c;
	cordic_t seed0_s3;
	cordic_t seed1_s3;
	side_t side_q [0:N];
	cordic_t cor0_q [0:N-1];
	cordic_t cor1_q [0:N-1];

	always_comb begin
		hsum_c = {12'd0, plo_s2} + {phi_s2, 32'd0} + (62'd1 << 27);
		dth_c = rneg_s2 ? -hsum_c[59:28] : hsum_c[59:28];
		nh_c = ctx_s2.heading + dth_c;
		t0_c = ctx_s2.heading - 32'h40000000;
		t1_c = nh_c - 32'h40000000;
		a0_c = t0_c[31] ? ctx_s2.heading : ctx_s2.heading + 32'h80000000;
		a1_c = t1_c[31] ? nh_c : nh_c + 32'h80000000;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seed0_s3.x <= CORDIC_GAIN;
			seed0_s3.y <= '0;
			seed0_s3.z <= $signed({{2{a0_c[31]}}, a0_c});
			seed1_s3.x <= CORDIC_GAIN;
			seed1_s3.y <= '0;
			seed1_s3.z <= $signed({{2{a1_c[31]}}, a1_c});
			side_q[0].px <= ctx_s2.pos_x;
			side_q[0].py <= ctx_s2.pos_y;
			side_q[0].nh <= nh_c;
			side_q[0].v <= ctx_s2.speed;
			side_q[0].d <= d_s2;
			side_q[0].arc <= arc_s2;
			side_q[0].wneg <= ctx_s2.turn_rate[27];
			side_q[0].wmag <= wmag_s2;
			side_q[0].last <= ctx_s2.last_in_batch;
			side_q[0].flip0 <= !t0_c[31];
			side_q[0].flip1 <= !t1_c[31];
			for (int k = 0; k < N; k++) begin
				side_q[k+1] <= side_q[k];
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cordic
		if (k == 0) begin : g_first
			ctrvpmu_cordic_cell u_c0 (
				.clk(clk), .en(en), .idx(5'(k)), .d(seed0_s3), .q(cor0_q[k])
			);
			ctrvpmu_cordic_cell u_c1 (
				.clk(clk), .en(en), .idx(5'(k)), .d(seed1_s3), .q(cor1_q[k])
			);
		end else begin : g_rest
			ctrvpmu_cordic_cell u_c0 (
				.clk(clk), .en(en), .idx(5'(k)), .d(cor0_q[k-1]), .q(cor0_q[k])
			);
			ctrvpmu_cordic_cell u_c1 (
				.clk(clk), .en(en), .idx(5'(k)), .d(cor1_q[k-1]), .q(cor1_q[k])
			);
		end
	end

	// Product stage: arc numerators and straight-line products.
	side_t sn;
	logic signed [CW-1:0] c0_c;
	logic signed [CW-1:0] s0_c;
	logic signed [CW-1:0] c1_c;
	logic signed [CW-1:0] s1_c;
	logic signed [58:0] nxp_s1p;
	logic signed [58:0] nyp_s1p;
	logic signed [67:0] stx_s1p;
	logic signed [67:0] sty_s1p;
	side_t sp_s1p;

	always_comb begin
		sn = side_q[N];
		c0_c = sn.flip0 ? -$signed(cor0_q[N-1].x) : $signed(cor0_q[N-1].x);
		s0_c = sn.flip0 ? -$signed(cor0_q[N-1].y) : $signed(cor0_q[N-1].y);
		c1_c = sn.flip1 ? -$signed(cor1_q[N-1].x) : $signed(cor1_q[N-1].x);
		s1_c = sn.flip1 ? -$signed(cor1_q[N-1].y) : $signed(cor1_q[N-1].y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nxp_s1p <= sn.v * ($signed({s1_c[CW-1], s1_c}) - $signed({s0_c[CW-1], s0_c}));
			nyp_s1p <= sn.v * ($signed({c0_c[CW-1], c0_c}) - $signed({c1_c[CW-1], c1_c}));
			stx_s1p <= sn.d * c0_c;
			sty_s1p <= sn.d * s0_c;
			sp_s1p <= sn;
		end
	end

	// Rounding stage: divider operands and straight-line offsets.
	logic [58:0] nxm_c;
	logic [58:0] nym_c;
	logic [DW-1:0] den_c;
	logic [67:0] stxm_c;
	logic [67:0] stym_c;
	logic [30:0] rx_c;
	logic [30:0] ry_c;
	div_t dx_seed_s2p;
	div_t dy_seed_s2p;
	side2_t side2_q [0:NW];
	div_t dvx_q [0:NW-1];
	div_t dvy_q [0:NW-1];

	always_comb begin
		nxm_c = nxp_s1p[58] ? 59'(-nxp_s1p) : 59'(nxp_s1p);
		nym_c = nyp_s1p[58] ? 59'(-nyp_s1p) : 59'(nyp_s1p);
		den_c = {sp_s1p.wmag, 6'd0};
		stxm_c = stx_s1p[67] ? 68'(-stx_s1p) : 68'(stx_s1p);
		stym_c = sty_s1p[67] ? 68'(-sty_s1p) : 68'(sty_s1p);
		rx_c = 31'((stxm_c + (68'd1 << 37)) >> 38);
		ry_c = 31'((stym_c + (68'd1 << 37)) >> 38);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_seed_s2p.rem <= '0;
			dx_seed_s2p.nq <= nxm_c[NW-1:0] + NW'(den_c >> 1);
			dx_seed_s2p.dv <= den_c;
			dy_seed_s2p.rem <= '0;
			dy_seed_s2p.nq <= nym_c[NW-1:0] + NW'(den_c >> 1);
			dy_seed_s2p.dv <= den_c;
			side2_q[0].px <= sp_s1p.px;
			side2_q[0].py <= sp_s1p.py;
			side2_q[0].nh <= sp_s1p.nh;
			side2_q[0].last <= sp_s1p.last;
			side2_q[0].arc <= sp_s1p.arc;
			side2_q[0].sx <= nxp_s1p[58] ^ sp_s1p.wneg;
			side2_q[0].sy <= nyp_s1p[58] ^ sp_s1p.wneg;
			side2_q[0].stdx <= stx_s1p[67] ? -$signed({1'b0, rx_c}) : $signed({1'b0, rx_c});
			side2_q[0].stdy <= sty_s1p[67] ? -$signed({1'b0, ry_c}) : $signed({1'b0, ry_c});
			for (int k = 0; k < NW; k++) begin
				side2_q[k+1] <= side2_q[k];
			end
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		if (k == 0) begin : g_first
			ctrvpmu_div_cell u_dx (.clk(clk), .en(en), .d(dx_seed_s2p), .q(dvx_q[k]));
			ctrvpmu_div_cell u_dy (.clk(clk), .en(en), .d(dy_seed_s2p), .q(dvy_q[k]));
		end else begin : g_rest
			ctrvpmu_div_cell u_dx (.clk(clk), .en(en), .d(dvx_q[k-1]), .q(dvx_q[k]));
			ctrvpmu_div_cell u_dy (.clk(clk), .en(en), .d(dvy_q[k-1]), .q(dvy_q[k]));
		end
	end

	// Final stage: choose model, add, saturate.
	side2_t sf;
	logic signed [57:0] ddx_c;
	logic signed [57:0] ddy_c;
	logic signed [57:0] sumx_c;
	logic signed [57:0] sumy_c;
	logic satx_c;
	logic saty_c;
	out_item_t res_c;
	out_item_t out_q;

	always_comb begin
		sf = side2_q[NW];
		if (sf.arc) begin
			ddx_c = sf.sx ? -$signed({2'b00, dvx_q[NW-1].nq}) : $signed({2'b00, dvx_q[NW-1].nq});
			ddy_c = sf.sy ? -$signed({2'b00, dvy_q[NW-1].nq}) : $signed({2'b00, dvy_q[NW-1].nq});
		end else begin
			ddx_c = $signed({{26{sf.stdx[31]}}, sf.stdx});
			ddy_c = $signed({{26{sf.stdy[31]}}, sf.stdy});
		end
		sumx_c = $signed({{26{sf.px[31]}}, sf.px}) + ddx_c;
		sumy_c = $signed({{26{sf.py[31]}}, sf.py}) + ddy_c;
		satx_c = sumx_c > 58'sd2147483647 || sumx_c < -58'sd2147483648;
		saty_c = sumy_c > 58'sd2147483647 || sumy_c < -58'sd2147483648;
		if (sumx_c > 58'sd2147483647) begin
			res_c.new_x = 32'sh7FFFFFFF;
		end else if (sumx_c < -58'sd2147483648) begin
			res_c.new_x = 32'sh80000000;
		end else begin
			res_c.new_x = sumx_c[31:0];
		end
		if (sumy_c > 58'sd2147483647) begin
			res_c.new_y = 32'sh7FFFFFFF;
		end else if (sumy_c < -58'sd2147483648) begin
			res_c.new_y = 32'sh80000000;
		end else begin
			res_c.new_y = sumy_c[31:0];
		end
		res_c.new_heading = sf.nh;
		res_c.saturated = satx_c || saty_c;
		res_c.last_out = sf.last;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res_c;
		end
	end

	assign out_data = out_q;

	// Valid bits follow the items through every stage.
	logic v_s1;
	logic v_s2;
	logic [N:0] cv_q;
	logic pv_s1p;
	logic [NW:0] dv_q;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			cv_q <= '0;
			pv_s1p <= 1'b0;
			dv_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			cv_q <= {cv_q[N-1:0], v_s2};
			pv_s1p <= cv_q[N];
			dv_q <= {dv_q[NW-1:0], pv_s1p};
			out_valid_q <= dv_q[NW];
		end
	end

	assign out_valid = out_valid_q;

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output register state");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.saturated) |->
		(out_data.new_x == 32'sh7FFFFFFF || out_data.new_x == 32'sh80000000 ||
		out_data.new_y == 32'sh7FFFFFFF || out_data.new_y == 32'sh80000000))
		else $error("saturated flag set without a clamped position");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en) |=> v_s1)
		else $error("stage 1 item lost during a stall");

endmodule
